@@ src/ple_pkg.sv @@
// Package for the positional list engine: request and result transfer types,
// request and status constants, and the control types shared by the cell row.
// Depends on nothing.
`default_nettype none

package ple_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;

    // Request types
    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_LOCATE = 3'd4;
    localparam logic [2:0] REQ_PRED   = 3'd5;
    localparam logic [2:0] REQ_SUCC   = 3'd6;

    // Result status
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BADPOS = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NOFIND = 3'd3;
    localparam logic [2:0] ST_NOPRED = 3'd4;
    localparam logic [2:0] ST_NOSUCC = 3'd5;

    typedef struct packed {
        logic [2:0]                req_type;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } ple_in_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [VALUE_W-1:0] result_value;
        logic [POS_W-1:0]          found_position;
        logic [POS_W-1:0]          list_length;
        logic                      is_empty;
    } ple_out_t;

    // Shift command broadcast to every cell for the cycle of an insert or delete.
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic [POS_W-1:0]          pos0;
        logic signed [VALUE_W-1:0] ins_value;
    } ple_shift_t;

    // What the probe wave looks for while a scan is running.
    typedef struct packed {
        logic                      locate;
        logic [POS_W-1:0]          target;
        logic signed [VALUE_W-1:0] key;
    } ple_probe_ctl_t;

    // Probe token handed from cell to cell towards the head of the row.
    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos1;
    } ple_probe_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } ple_state_t;

endpackage

`default_nettype wire

@@ src/ple_cell.sv @@
// One storage cell of the list row: holds a single element, shifts with its
// neighbours on insert and delete, and passes the probe token one step a cycle.
// Depends on ple_pkg.
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                          clk,
    input  wire ple_pkg::ple_shift_t           shift,
    input  wire ple_pkg::ple_probe_ctl_t       pctl,
    input  wire logic [CNT_W-1:0]              count,
    input  wire logic signed [31:0]            left_value,
    input  wire logic signed [31:0]            right_value,
    output logic signed [31:0]                 value,
    input  wire ple_pkg::ple_probe_t           probe_in,
    output ple_pkg::ple_probe_t                probe_out
);
    import ple_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    ple_probe_t                probe_reg;
    ple_probe_t                probe_next;
    logic                      hit;

    // An insert opens a gap at its position; a delete closes one.
    always_comb
    begin
        value_next = value_reg;
        if (shift.ins_en)
        begin
            if (INDEX == int'(shift.pos0))
                value_next = shift.ins_value;
            else if (INDEX > int'(shift.pos0))
                value_next = left_value;
        end
        else if (shift.del_en && (INDEX >= int'(shift.pos0)))
        begin
            value_next = right_value;
        end
    end

    // Lower cells overwrite the token, so the first match wins at the head.
    always_comb
    begin
        if (pctl.locate)
            hit = (INDEX < int'(count)) && (value_reg == pctl.key);
        else
            hit = (INDEX == int'(pctl.target));

        if (hit)
        begin
            probe_next.hit   = 1'b1;
            probe_next.value = value_reg;
            probe_next.pos1  = POS_W'(INDEX + 1);
        end
        else
        begin
            probe_next = probe_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        probe_reg <= probe_next;
    end

    assign value     = value_reg;
    assign probe_out = probe_reg;

endmodule

`default_nettype wire

@@ src/positional_list_engine.sv @@
// Top level of the positional list engine: request decoding, element count,
// scan sequencing, result register and a row of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.
//
//   Channel   Signals                 Handshake
//   --------  ----------------------  -----------------------------------------
//   request   start, busy, request    transfer when start is high, busy is low
//   result    done, result            one-cycle strobe; cannot be held off
//
// Clear, insert, delete, every request rejected on its position or a full
// store, and the unused request code need no scan: the result appears in
// the cycle after the transfer and busy stays low, so requests may follow
// back to back. Read, predecessor, successor and locate send a probe token
// from the tail cell to the head cell, one cell per cycle; busy is high
// while the token moves, and no new request is accepted until it is low.
// Reset clears the element count and the controller; the cell contents are
// left undefined, as no cell at or beyond the count is ever read.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ple_pkg::ple_in_t   request,
    output logic                    done,
    output ple_pkg::ple_out_t       result
);
    import ple_pkg::*;

    // Count width holds CAPACITY itself; comparisons against the 7-bit
    // position use one bit more than the wider of the two.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    ple_state_t           state_reg;
    ple_state_t           state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic [CNT_W-1:0]     scan_cnt_next;
    logic                 done_reg;
    logic                 done_next;
    ple_out_t             result_reg;
    ple_out_t             result_next;
    ple_probe_ctl_t       probe_ctl_reg;
    ple_probe_ctl_t       probe_ctl_next;

    ple_shift_t           shift_ctl;
    logic                 accept;

    // Decode of the incoming request
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 pos_outside;
    logic                 ins_outside;
    logic                 store_full;
    logic [2:0]           dec_status;
    logic                 dec_scan;
    logic                 dec_ins;
    logic                 dec_del;
    logic [CNT_W-1:0]     dec_count;
    logic [POS_W-1:0]     dec_target;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    ple_probe_t                probe_w    [CAPACITY+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_SCAN);

    assign pos_ext     = CMP_W'(request.position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign pos_outside = (request.position == '0) || (pos_ext > cnt_ext);
    assign ins_outside = (request.position == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
    assign store_full  = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        dec_status = ST_OK;
        dec_scan   = 1'b0;
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_count  = count_reg;
        dec_target = request.position - POS_W'(1);

        case (request.req_type)
            REQ_CLEAR:
            begin
                dec_count = '0;
            end
            REQ_INSERT:
            begin
                // The position is checked before the store is found full.
                if (ins_outside)
                    dec_status = ST_BADPOS;
                else if (store_full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_ins   = 1'b1;
                    dec_count = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (pos_outside)
                    dec_status = ST_BADPOS;
                else
                begin
                    dec_del   = 1'b1;
                    dec_count = count_reg - CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                if (pos_outside)
                    dec_status = ST_BADPOS;
                else
                    dec_scan = 1'b1;
            end
            REQ_PRED:
            begin
                dec_target = request.position - POS_W'(2);
                if (pos_outside)
                    dec_status = ST_BADPOS;
                else if (request.position == POS_W'(1))
                    dec_status = ST_NOPRED;
                else
                    dec_scan = 1'b1;
            end
            REQ_SUCC:
            begin
                dec_target = request.position;
                if (pos_outside)
                    dec_status = ST_BADPOS;
                else if (pos_ext == cnt_ext)
                    dec_status = ST_NOSUCC;
                else
                    dec_scan = 1'b1;
            end
            REQ_LOCATE:
            begin
                // An empty list still runs the scan and reports not found.
                dec_scan = 1'b1;
            end
            default:
            begin
                // The unused code leaves the list alone and reports success.
            end
        endcase
    end

    // The shift takes effect in the cells at the same edge as the transfer.
    always_comb
    begin
        shift_ctl.ins_en    = accept && dec_ins;
        shift_ctl.del_en    = accept && dec_del;
        shift_ctl.pos0      = request.position - POS_W'(1);
        shift_ctl.ins_value = request.item_value;
    end

    // Sequencer: a request with no scan answers at once; a scan waits until the
    // token has reached the head cell.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        probe_ctl_next = probe_ctl_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = dec_count;
                    if (dec_scan)
                    begin
                        state_next            = ST_SCAN;
                        scan_cnt_next         = '0;
                        probe_ctl_next.locate = (request.req_type == REQ_LOCATE);
                        probe_ctl_next.target = dec_target;
                        probe_ctl_next.key    = request.item_value;
                    end
                    else
                    begin
                        done_next                  = 1'b1;
                        result_next.status         = dec_status;
                        result_next.result_value   = '0;
                        result_next.found_position = '0;
                        result_next.list_length    = POS_W'(dec_count);
                        result_next.is_empty       = (dec_count == '0);
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(CAPACITY))
                begin
                    state_next              = ST_IDLE;
                    done_next               = 1'b1;
                    result_next.list_length = POS_W'(count_reg);
                    result_next.is_empty    = (count_reg == '0);
                    if (probe_ctl_reg.locate)
                    begin
                        result_next.result_value = '0;
                        if (probe_w[0].hit)
                        begin
                            result_next.status         = ST_OK;
                            result_next.found_position = probe_w[0].pos1;
                        end
                        else
                        begin
                            result_next.status         = ST_NOFIND;
                            result_next.found_position = '0;
                        end
                    end
                    else
                    begin
                        result_next.status         = ST_OK;
                        result_next.result_value   = probe_w[0].value;
                        result_next.found_position = '0;
                    end
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        probe_ctl_reg <= probe_ctl_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The row of cells: element k of the list lives in cell k-1. The token
    // enters empty behind the tail cell and moves one cell a cycle to cell 0.
    assign probe_w[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ple_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .shift       (shift_ctl),
            .pctl        (probe_ctl_reg),
            .count       (count_reg),
            .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
            .value       (cell_value[i]),
            .probe_in    (probe_w[i + 1]),
            .probe_out   (probe_w[i])
        );
    end

    // The result strobe never fires while a scan is still running.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !done)
        else $error("result strobe raised during a scan");

    // The element count never passes the capacity of the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    // A locate always starts a scan in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.req_type == REQ_LOCATE)) |=> busy)
        else $error("locate did not start a scan");

    // A full status is only ever reported with the store at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

endmodule

`default_nettype wire
